FILE: hdl/four_channel_dma_controller_unit_macros.svh
// Assertion macros used by the top-level file, which checks itself.
`ifndef FOUR_CHANNEL_DMA_CONTROLLER_UNIT_MACROS_SVH
`define FOUR_CHANNEL_DMA_CONTROLLER_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define FCD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define FCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fcdma_pkg.sv
package fcdma_pkg;

	localparam int unsigned CHANNELS_DEF    = 4;
	localparam logic [31:0] LATCH_BELOW_DEF = 32'h0200_0000;

	localparam logic [31:0] MASK_27  = 32'h07FF_FFFF;
	localparam logic [31:0] MASK_28  = 32'h0FFF_FFFF;
	localparam logic [15:0] CMASK_14 = 16'h3FFF;
	localparam logic [15:0] CMASK_16 = 16'hFFFF;
	localparam logic [3:0]  STEP_MASK = 4'hF;

	localparam logic [1:0] MODE_REG  = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_RDAT = 2'd2;

	localparam logic [1:0] PER_HBLANK = 2'd1;
	localparam logic [1:0] PER_VBLANK = 2'd2;

	localparam logic [1:0] REG_SRC = 2'd0;
	localparam logic [1:0] REG_DST = 2'd1;
	localparam logic [1:0] REG_CNT = 2'd2;
	localparam logic [1:0] REG_CTL = 2'd3;

	localparam logic [1:0] START_NOW    = 2'd0;
	localparam logic [1:0] START_VBLANK = 2'd1;
	localparam logic [1:0] START_HBLANK = 2'd2;

	localparam logic [1:0] ADDR_DEC   = 2'd1;
	localparam logic [1:0] ADDR_FIXED = 2'd2;

	// Classified input item, as it leaves the front part.
	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  channel;
		logic [1:0]  reg_select;
		logic [31:0] value;
		logic [1:0]  period;
	} cmd_t;

	// Result item.
	typedef struct packed {
		logic        kind;
		logic [31:0] address;
		logic [31:0] data;
		logic        is_halfword;
		logic        sequential;
		logic [1:0]  xfer_channel;
		logic        transfer_done;
	} res_t;

	function automatic logic [3:0] make_step(input logic [1:0] typ, input logic wrd);
		logic [3:0] sz;
		sz = wrd ? 4'd4 : 4'd2;
		case (typ)
			ADDR_DEC:   make_step = (4'd0 - sz) & STEP_MASK;
			ADDR_FIXED: make_step = 4'd0;
			default:    make_step = sz;
		endcase
	endfunction

	function automatic logic [31:0] apply_step(input logic [31:0] a, input logic [3:0] s);
		apply_step = a + {{28{s[3]}}, s};
	endfunction

endpackage

FILE: hdl/fcdma_front.sv
module fcdma_front
	import fcdma_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_user,
	input  logic [69:0] in_data,
	output logic        q_valid,
	input  logic        q_ready,
	output cmd_t        q_cmd
);
	// Two-entry queue; read data is folded into value for data returns.
	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic       push, pop;

	always_comb begin
		c.mode       = in_user;
		c.channel    = in_data[1:0];
		c.reg_select = in_data[3:2];
		c.period     = in_data[37:36];
		c.value      = (in_user == MODE_RDAT) ? in_data[69:38] : in_data[35:4];
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: hdl/fcdma_back.sv
module fcdma_back
	import fcdma_pkg::*;
#(
	parameter int unsigned CHANNELS    = CHANNELS_DEF,
	parameter logic [31:0] LATCH_BELOW = LATCH_BELOW_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	output logic  q_ready,
	input  cmd_t  q_cmd,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);
	logic [31:0] src_q [4], dst_q [4], csrc_q [4], cdst_q [4];
	logic [15:0] cnt_q [4], ctl_q [4];
	logic [16:0] rem_q [4];
	logic [3:0]  sst_q [4], dst_st_q [4];
	logic [3:0]  half_q, seq_q, act_q;
	logic [7:0]  pend_q;
	logic [31:0] latch_q;
	logic        await_q;
	res_t        res_q;
	logic        ov_q;

	logic        take;
	assign q_ready   = !ov_q || out_ready;
	assign take      = q_valid && q_ready;
	assign out_valid = ov_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		logic [3:0]  act, half, seq, cand;
		logic [7:0]  pend;
		logic [15:0] ctl [4];
		logic [16:0] rem [4];
		logic [31:0] cs [4], cd [4];
		logic [3:0]  ss [4], ds [4];
		logic        found, emitv, dodw;
		logic [1:0]  ch, cc;
		logic [31:0] wd;
		logic [15:0] cm;
		logic [16:0] rn;
		res_t        r;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				src_q[i] <= '0; dst_q[i] <= '0; csrc_q[i] <= '0; cdst_q[i] <= '0;
				cnt_q[i] <= '0; ctl_q[i] <= '0; rem_q[i] <= '0;
				sst_q[i] <= '0; dst_st_q[i] <= '0;
			end
			half_q <= '0; seq_q <= '0; act_q <= '0; pend_q <= '0;
			latch_q <= '0; await_q <= 1'b0; ov_q <= 1'b0; res_q <= '0;
		end else begin
			if (!take && out_ready) ov_q <= 1'b0;
			if (take) begin
				act = act_q; half = half_q; seq = seq_q; pend = pend_q;
				ctl = ctl_q; rem = rem_q; cs = csrc_q; cd = cdst_q;
				ss = sst_q; ds = dst_st_q;
				emitv = 1'b0; dodw = 1'b0; ch = 2'd0; wd = '0; found = 1'b0;
				r = '0; cand = '0; cc = 2'd0;
				case (q_cmd.mode)
					MODE_REG: begin
						if (32'(q_cmd.channel) < CHANNELS) begin
							case (q_cmd.reg_select)
								REG_SRC: src_q[q_cmd.channel] <= q_cmd.value;
								REG_DST: dst_q[q_cmd.channel] <= q_cmd.value;
								REG_CNT: cnt_q[q_cmd.channel] <= q_cmd.value[15:0];
								default: ctl[q_cmd.channel] = q_cmd.value[15:0];
							endcase
						end
					end
					MODE_TICK: begin
						if (!await_q) begin
							for (int i = 0; i < 4; i++) begin
								if (i < CHANNELS) begin
									if (!ctl[i][15]) begin
										act[i] = 1'b0; pend[i] = 1'b0; pend[i+4] = 1'b0;
									end else if (!(act[i] || pend[i] || pend[i+4])) begin
										cm = (i == 3) ? CMASK_16 : CMASK_14;
										rem[i] = ((cnt_q[i] & cm) != 0) ? {1'b0, cnt_q[i] & cm}
											: {1'b0, cm} + 17'd1;
										cs[i] = src_q[i] & ((i == 0) ? MASK_27 : MASK_28);
										cd[i] = dst_q[i] & ((i == 3) ? MASK_28 : MASK_27);
										half[i] = !ctl[i][10];
										ds[i] = make_step(ctl[i][6:5], ctl[i][10]);
										ss[i] = make_step(ctl[i][8:7], ctl[i][10]);
										seq[i] = 1'b0;
										case (ctl[i][13:12])
											START_NOW:    act[i] = 1'b1;
											START_VBLANK: pend[i+4] = 1'b1;
											START_HBLANK: pend[i] = 1'b1;
											default:      ctl[i][15] = 1'b0;
										endcase
									end
								end
							end
							if (q_cmd.period == PER_HBLANK) cand = pend[3:0];
							else if (q_cmd.period == PER_VBLANK) cand = pend[7:4];
							for (int i = 3; i >= 0; i--) if (cand[i]) cc = 2'(i);
							if (cand != 0) begin
								if (q_cmd.period == PER_VBLANK) pend[{1'b1, cc}] = 1'b0;
								else pend[{1'b0, cc}] = 1'b0;
								act[cc] = 1'b1;
							end
							for (int i = 3; i >= 0; i--) if (act[i]) begin
								ch = 2'(i); found = 1'b1;
							end
							if (found) begin
								if (cs[ch] < LATCH_BELOW) begin
									dodw = 1'b1; wd = latch_q;
								end else begin
									await_q <= 1'b1; emitv = 1'b1;
									r.kind = 1'b0; r.address = cs[ch]; r.data = '0;
									r.is_halfword = half[ch]; r.sequential = seq[ch];
									r.xfer_channel = ch; r.transfer_done = 1'b0;
								end
							end
						end
					end
					MODE_RDAT: begin
						if (await_q) begin
							await_q <= 1'b0;
							for (int i = 3; i >= 0; i--) if (act[i]) begin
								ch = 2'(i); found = 1'b1;
							end
							if (found) begin
								wd = q_cmd.value;
								if (half[ch]) begin
									wd = {16'd0, wd[15:0]};
									latch_q <= {wd[15:0], wd[15:0]};
								end else latch_q <= wd;
								dodw = 1'b1;
							end
						end
					end
					default: ;
				endcase
				if (dodw) begin
					if (half[ch]) wd = {16'd0, wd[15:0]};
					rn = rem[ch] - 17'd1;
					rem[ch] = rn;
					r.kind = 1'b1; r.address = cd[ch]; r.data = wd;
					r.is_halfword = half[ch]; r.sequential = seq[ch];
					r.xfer_channel = ch; r.transfer_done = (rn == 17'd0);
					if (rn == 17'd0) begin
						act[ch] = 1'b0; ctl[ch][15] = 1'b0;
					end
					seq[ch] = 1'b1;
					cs[ch] = apply_step(cs[ch], ss[ch]);
					cd[ch] = apply_step(cd[ch], ds[ch]);
					emitv = 1'b1;
				end
				act_q <= act; half_q <= half; seq_q <= seq; pend_q <= pend;
				ctl_q <= ctl; rem_q <= rem; csrc_q <= cs; cdst_q <= cd;
				sst_q <= ss; dst_st_q <= ds;
				if (emitv) begin
					ov_q <= 1'b1; res_q <= r;
				end else if (out_ready) begin
					ov_q <= 1'b0;
				end
			end
		end
	end
endmodule

FILE: hdl/four_channel_dma_controller_unit.sv
// Channel   Group   Fields (lowest bit up)
// s_axis    tuser   mode[1:0]
//           tdata   channel[1:0] reg_select[3:2] write_value[35:4] period[37:36]
//                   read_data[69:38], zero-filled to 72 bits
// m_axis    tuser   kind
//           tlast   transfer_done
//           tdata   address[31:0] data[63:32] is_halfword[64] sequential[65]
//                   xfer_channel[67:66], zero-filled to 72 bits
//
// An input transfer lands in a two-entry queue, from which the back part takes it when
// ready, and registers its bus transfer, which is offered on m_axis the following cycle.
// The back part handles one item per cycle while m_axis is not stalled, so items may follow back to back.
// While a result waits unaccepted the back part takes nothing and the queue fills;
// s_axis_tready falls once both entries are held.
// arst_n clears all channel state and the queue asynchronously.
`include "four_channel_dma_controller_unit_macros.svh"
module four_channel_dma_controller_unit
	import fcdma_pkg::*;
#(
	parameter int unsigned CHANNELS    = CHANNELS_DEF,
	parameter logic [31:0] LATCH_BELOW = LATCH_BELOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,  // mode
	input  logic [71:0] s_axis_tdata,  // channel, reg_select, write_value, period, read_data
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic        m_axis_tuser,  // kind
	output logic        m_axis_tlast,
	output logic [71:0] m_axis_tdata   // address, data, is_halfword, sequential, xfer_channel
);
	logic q_valid, q_ready;
	cmd_t q_cmd;
	res_t res;

	fcdma_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_user(s_axis_tuser), .in_data(s_axis_tdata[69:0]),
		.q_valid, .q_ready, .q_cmd
	);

	fcdma_back #(.CHANNELS(CHANNELS), .LATCH_BELOW(LATCH_BELOW)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.transfer_done;
	assign m_axis_tdata = {4'b0000, res.xfer_channel, res.sequential, res.is_halfword,
		res.data, res.address};

	`FCD_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tlast, m_axis_tuser, m_axis_tdata}), "result dropped under stall")
	`FCD_ASSERT_IMPL(a_rd_nodata, clk, arst_n, m_axis_tvalid && !res.kind, res.data == 32'd0 && !res.transfer_done, "read request with data")
endmodule
